>>> design/tet_pkg.sv
// ---------------------------------------------------------------------------
// tet_pkg
// Shared types and constants for the timed event table: table geometry,
// field widths, action and result codes, slot entry and control structs.
// ---------------------------------------------------------------------------
package tet_pkg;

    // Table geometry
    localparam int ENTRIES     = 32;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int ACT_W  = 3;
    localparam int KIND_W = 3;
    localparam int ID_W   = 32;
    localparam int TIME_W = 32;
    localparam int SESS_W = 32;
    localparam int CODE_W = 16;
    localparam int ARG_W  = 32;

    // Stream payload widths (packed fields rounded up to whole bytes)
    localparam int IN_DATA_W  = 144;
    localparam int OUT_FLD_W  = 1 + ID_W + SESS_W + CODE_W + ARG_W;
    localparam int OUT_DATA_W = 120;
    localparam int OUT_PAD_W  = OUT_DATA_W - OUT_FLD_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [ID_W-1:0]  ID_NONE  = {ID_W{1'b1}};

    // Requested action
    typedef enum logic [ACT_W-1:0] {
        ACT_ENTER    = 3'd0,
        ACT_REM_ID   = 3'd1,
        ACT_REM_SESS = 3'd2,
        ACT_EXEC     = 3'd3,
        ACT_CHECK    = 3'd4
    } tet_action_t;

    // Result kind
    typedef enum logic [KIND_W-1:0] {
        KIND_ENTER   = 3'd0,
        KIND_REMOVED = 3'd1,
        KIND_FIRED   = 3'd2,
        KIND_NONE    = 3'd3,
        KIND_CHECK   = 3'd4
    } tet_kind_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } tet_state_t;

    // One table slot
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] due;
        logic [SESS_W-1:0] session;
        logic [CODE_W-1:0] code;
        logic [ARG_W-1:0]  arg;
    } tet_entry_t;

    // Table access from the sequencer
    typedef struct packed {
        logic             wr_en;
        logic             clr_en;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] rd_addr;
        tet_entry_t       wr_data;
    } tet_tbl_req_t;

    // Search key for the compare unit
    typedef struct packed {
        tet_action_t       op;
        logic [TIME_W-1:0] event_time;
        logic [SESS_W-1:0] session;
        logic [ID_W-1:0]   event_id;
    } tet_key_t;

endpackage

>>> design/timed_event_table_core.sv
// ---------------------------------------------------------------------------
// timed_event_table_core
// Table of timed events with enter, remove by id, remove by session,
// execute-at-time and session check, one request at a time.
//
//   channel   dir  tdata                                   tuser    tlast
//   s_*       in   event_time, session, event_id,          action   -
//                  callback_code, callback_arg
//   m_*       out  ok, out_id, out_session, out_code,      kind     last
//                  out_arg
//
// A request is accepted in the idle state, then visits up to ENTRIES slots
// on the table read port, one per cycle while no result is held back, and
// ends with the closing result once the result side can take it.
// Enter, remove by id and check stop at the first hit; the others visit
// every slot. Execute waits in place while a fired result is held back.
// Reset clears the valid flags at once; no clearing pass is needed.
// Unknown actions are taken and dropped without a result.
// ---------------------------------------------------------------------------
module timed_event_table_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // event_time[31:0], session[63:32], event_id[95:64],
    // callback_code[111:96], callback_arg[143:112]
    input  logic [tet_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[2:0]
    input  logic [tet_pkg::ACT_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok[0], out_id[32:1], out_session[64:33], out_code[80:65],
    // out_arg[112:81], zero pad[119:113]
    output logic [tet_pkg::OUT_DATA_W-1:0]  m_tdata,
    // kind[2:0]
    output logic [tet_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast
);

    tet_pkg::tet_tbl_req_t          tbl_req;
    tet_pkg::tet_entry_t            rd_data;
    logic [tet_pkg::ENTRIES-1:0]    valid;
    tet_pkg::tet_key_t              key;
    logic                           match;

    // Slot storage
    tet_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (tbl_req),
        .rd_data (rd_data),
        .valid   (valid)
    );

    // Shared compare unit
    tet_cmp u_cmp (
        .slot  (rd_data),
        .key   (key),
        .match (match)
    );

    // Sequencer and result register
    tet_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .tbl_req  (tbl_req),
        .rd_data  (rd_data),
        .valid    (valid),
        .key      (key),
        .match    (match)
    );

endmodule

>>> design/tet_table.sv
// ---------------------------------------------------------------------------
// tet_table
// Slot storage: entry memory with one write port and one registered read
// port, plus a valid flag per slot in flip-flops cleared by reset.
// ---------------------------------------------------------------------------
module tet_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tet_pkg::tet_tbl_req_t         req,
    output tet_pkg::tet_entry_t           rd_data,
    output logic [tet_pkg::ENTRIES-1:0]   valid
);

    tet_pkg::tet_entry_t mem [tet_pkg::ENTRIES];

    // Write on enter, read the slot the sequencer looks at next
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.idx] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

    // Set on enter, drop on remove or fire
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid <= '0;
        end
        else if (req.wr_en)
        begin
            valid[req.idx] <= 1'b1;
        end
        else if (req.clr_en)
        begin
            valid[req.idx] <= 1'b0;
        end
    end

endmodule

>>> design/tet_cmp.sv
// ---------------------------------------------------------------------------
// tet_cmp
// Shared compare unit: picks the slot field and key for the current action
// and reports a match (equal for ids and sessions, at-or-before for time).
// ---------------------------------------------------------------------------
module tet_cmp (
    input  tet_pkg::tet_entry_t slot,
    input  tet_pkg::tet_key_t   key,
    output logic                match
);

    logic [31:0] opa;
    logic [31:0] opb;

    // Select operands for the action
    always_comb
    begin
        case (key.op)
            tet_pkg::ACT_REM_ID:
            begin
                opa = slot.id;
                opb = key.event_id;
            end
            tet_pkg::ACT_REM_SESS, tet_pkg::ACT_CHECK:
            begin
                opa = slot.session;
                opb = key.session;
            end
            tet_pkg::ACT_EXEC:
            begin
                opa = slot.due;
                opb = key.event_time;
            end
            default:
            begin
                opa = '0;
                opb = '0;
            end
        endcase
    end

    // Unsigned compare
    assign match = (key.op == tet_pkg::ACT_EXEC) ? (opa <= opb) : (opa == opb);

endmodule

>>> design/tet_ctrl.sv
// ---------------------------------------------------------------------------
// tet_ctrl
// Sequencer: latches one transaction, walks the slots through the compare
// unit one per cycle except while execute holds back a fired result, updates
// the table, keeps the id counter and drives the registered result stream.
// ---------------------------------------------------------------------------
module tet_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    // Request side
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tet_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [tet_pkg::ACT_W-1:0]       s_tuser,
    // Result side
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tet_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [tet_pkg::KIND_W-1:0]      m_tuser,
    output logic                            m_tlast,
    // Table and compare unit
    output tet_pkg::tet_tbl_req_t           tbl_req,
    input  tet_pkg::tet_entry_t             rd_data,
    input  logic [tet_pkg::ENTRIES-1:0]     valid,
    output tet_pkg::tet_key_t               key,
    input  logic                            match
);

    tet_pkg::tet_state_t state_reg, state_next;

    logic [tet_pkg::IDX_W-1:0]  idx_reg, idx_next;
    tet_pkg::tet_action_t       op_reg, op_next;
    logic                       found_reg, found_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [tet_pkg::CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic [tet_pkg::ID_W-1:0]   id_cnt_reg, id_cnt_next;
    logic                       out_valid_reg, out_valid_next;

    logic [tet_pkg::TIME_W-1:0] time_reg, time_next;
    logic [tet_pkg::SESS_W-1:0] sess_reg, sess_next;
    logic [tet_pkg::ID_W-1:0]   eid_reg, eid_next;
    logic [tet_pkg::CODE_W-1:0] code_reg, code_next;
    logic [tet_pkg::ARG_W-1:0]  arg_reg, arg_next;
    tet_pkg::tet_entry_t        pend_reg, pend_next;

    tet_pkg::tet_kind_t         out_kind_reg, out_kind_next;
    logic                       out_ok_reg, out_ok_next;
    logic [tet_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic [tet_pkg::SESS_W-1:0] out_sess_reg, out_sess_next;
    logic [tet_pkg::CODE_W-1:0] out_code_reg, out_code_next;
    logic [tet_pkg::ARG_W-1:0]  out_arg_reg, out_arg_next;
    logic                       out_last_reg, out_last_next;

    logic                       act_known;
    logic                       can_emit;
    logic                       idx_last;
    logic                       slot_valid;
    logic                       step;
    logic                       leave;
    logic                       scan_done;
    logic [tet_pkg::ID_W-1:0]   new_id;

    assign act_known  = s_tuser inside {tet_pkg::ACT_ENTER, tet_pkg::ACT_REM_ID,
                                        tet_pkg::ACT_REM_SESS, tet_pkg::ACT_EXEC,
                                        tet_pkg::ACT_CHECK};
    assign can_emit   = !out_valid_reg || m_tready;
    assign idx_last   = (idx_reg == tet_pkg::LAST_IDX);
    assign slot_valid = valid[idx_reg];

    // Next id skips the all-ones value
    assign new_id = ((id_cnt_reg + 1'b1) == tet_pkg::ID_NONE) ? '0 : id_cnt_reg + 1'b1;

    assign key.op         = op_reg;
    assign key.event_time = time_reg;
    assign key.session    = sess_reg;
    assign key.event_id   = eid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tet_pkg::ST_IDLE:
            begin
                if (s_tvalid && act_known)
                begin
                    state_next = tet_pkg::ST_SCAN;
                end
            end
            tet_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = tet_pkg::ST_FINISH;
                end
            end
            tet_pkg::ST_FINISH:
            begin
                if (can_emit)
                begin
                    state_next = tet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tet_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = (state_reg == tet_pkg::ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tuser  = out_kind_reg;
        m_tlast  = out_last_reg;
        m_tdata  = {{tet_pkg::OUT_PAD_W{1'b0}}, out_arg_reg, out_code_reg,
                    out_sess_reg, out_id_reg, out_ok_reg};
    end

    // Scan datapath, table access and result register loading
    always_comb
    begin
        idx_next        = idx_reg;
        op_next         = op_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        fire_cnt_next   = fire_cnt_reg;
        id_cnt_next     = id_cnt_reg;
        time_next       = time_reg;
        sess_next       = sess_reg;
        eid_next        = eid_reg;
        code_next       = code_reg;
        arg_next        = arg_reg;
        pend_next       = pend_reg;

        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_ok_next     = out_ok_reg;
        out_id_next     = out_id_reg;
        out_sess_next   = out_sess_reg;
        out_code_next   = out_code_reg;
        out_arg_next    = out_arg_reg;
        out_last_next   = out_last_reg;

        tbl_req.wr_en           = 1'b0;
        tbl_req.clr_en          = 1'b0;
        tbl_req.idx             = idx_reg;
        tbl_req.rd_addr         = '0;
        tbl_req.wr_data.id      = new_id;
        tbl_req.wr_data.due     = time_reg;
        tbl_req.wr_data.session = sess_reg;
        tbl_req.wr_data.code    = code_reg;
        tbl_req.wr_data.arg     = arg_reg;

        step      = 1'b1;
        leave     = 1'b0;
        scan_done = 1'b0;

        case (state_reg)
            tet_pkg::ST_IDLE:
            begin
                // Latch the transaction, start at slot zero
                if (s_tvalid)
                begin
                    op_next         = tet_pkg::tet_action_t'(s_tuser);
                    time_next       = s_tdata[31:0];
                    sess_next       = s_tdata[63:32];
                    eid_next        = s_tdata[95:64];
                    code_next       = s_tdata[111:96];
                    arg_next        = s_tdata[143:112];
                    idx_next        = '0;
                    found_next      = 1'b0;
                    pend_valid_next = 1'b0;
                    fire_cnt_next   = '0;
                end
            end
            tet_pkg::ST_SCAN:
            begin
                case (op_reg)
                    tet_pkg::ACT_ENTER:
                    begin
                        // Take the lowest free slot
                        if (!slot_valid)
                        begin
                            tbl_req.wr_en = 1'b1;
                            id_cnt_next   = new_id;
                            found_next    = 1'b1;
                            leave         = 1'b1;
                        end
                    end
                    tet_pkg::ACT_REM_ID:
                    begin
                        // Drop the first matching id
                        if (slot_valid && match)
                        begin
                            tbl_req.clr_en = 1'b1;
                            found_next     = 1'b1;
                            leave          = 1'b1;
                        end
                    end
                    tet_pkg::ACT_REM_SESS:
                    begin
                        // Drop every entry of the session
                        if (slot_valid && match)
                        begin
                            tbl_req.clr_en = 1'b1;
                        end
                    end
                    tet_pkg::ACT_CHECK:
                    begin
                        if (slot_valid && match)
                        begin
                            found_next = 1'b1;
                            leave      = 1'b1;
                        end
                    end
                    tet_pkg::ACT_EXEC:
                    begin
                        // Hold one fired entry back so the final one can carry last
                        if (slot_valid && match)
                        begin
                            if (fire_cnt_reg == tet_pkg::CNT_W'(tet_pkg::MAX_RESULTS))
                            begin
                                leave = 1'b1;
                            end
                            else if (pend_valid_reg && !can_emit)
                            begin
                                step = 1'b0;
                            end
                            else
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = tet_pkg::KIND_FIRED;
                                    out_ok_next    = 1'b0;
                                    out_id_next    = pend_reg.id;
                                    out_sess_next  = pend_reg.session;
                                    out_code_next  = pend_reg.code;
                                    out_arg_next   = pend_reg.arg;
                                    out_last_next  = 1'b0;
                                end
                                pend_next       = rd_data;
                                pend_valid_next = 1'b1;
                                fire_cnt_next   = fire_cnt_reg + 1'b1;
                                tbl_req.clr_en  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        leave = 1'b1;
                    end
                endcase

                scan_done = step && (leave || idx_last);

                // Advance the slot pointer and prefetch the next entry
                if (step)
                begin
                    idx_next        = idx_reg + 1'b1;
                    tbl_req.rd_addr = idx_last ? '0 : idx_reg + 1'b1;
                end
                else
                begin
                    tbl_req.rd_addr = idx_reg;
                end
            end
            tet_pkg::ST_FINISH:
            begin
                // Load the closing result
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_ok_next     = 1'b0;
                    out_id_next     = tet_pkg::ID_NONE;
                    out_sess_next   = '0;
                    out_code_next   = '0;
                    out_arg_next    = '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    case (op_reg)
                        tet_pkg::ACT_ENTER:
                        begin
                            out_kind_next = tet_pkg::KIND_ENTER;
                            out_ok_next   = found_reg;
                            out_id_next   = found_reg ? id_cnt_reg : tet_pkg::ID_NONE;
                        end
                        tet_pkg::ACT_CHECK:
                        begin
                            out_kind_next = tet_pkg::KIND_CHECK;
                            out_ok_next   = found_reg;
                        end
                        tet_pkg::ACT_EXEC:
                        begin
                            if (pend_valid_reg)
                            begin
                                out_kind_next = tet_pkg::KIND_FIRED;
                                out_id_next   = pend_reg.id;
                                out_sess_next = pend_reg.session;
                                out_code_next = pend_reg.code;
                                out_arg_next  = pend_reg.arg;
                            end
                            else
                            begin
                                out_kind_next = tet_pkg::KIND_NONE;
                            end
                        end
                        default:
                        begin
                            out_kind_next = tet_pkg::KIND_REMOVED;
                        end
                    endcase
                end
            end
            default:
            begin
                idx_next = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tet_pkg::ST_IDLE;
            idx_reg        <= '0;
            op_reg         <= tet_pkg::ACT_ENTER;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            fire_cnt_reg   <= '0;
            id_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            op_reg         <= op_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            fire_cnt_reg   <= fire_cnt_next;
            id_cnt_reg     <= id_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        time_reg     <= time_next;
        sess_reg     <= sess_next;
        eid_reg      <= eid_next;
        code_reg     <= code_next;
        arg_reg      <= arg_next;
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_ok_reg   <= out_ok_next;
        out_id_reg   <= out_id_next;
        out_sess_reg <= out_sess_next;
        out_code_reg <= out_code_next;
        out_arg_reg  <= out_arg_next;
        out_last_reg <= out_last_next;
    end

endmodule

>>> design/tet_checker.sv
// ---------------------------------------------------------------------------
// tet_checker
// Port-level checks for the timed event table core, bound to the top level.
// ---------------------------------------------------------------------------
module tet_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [tet_pkg::ACT_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tet_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [tet_pkg::KIND_W-1:0]      m_tuser,
    input logic                            m_tlast
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    // Only fired events may be followed by more results of the same request
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != tet_pkg::KIND_FIRED) |-> m_tlast)
        else $error("non-fire result without last");

    // Nothing due and failed enter carry the empty id
    a_empty_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == tet_pkg::KIND_NONE)
                     || ((m_tuser == tet_pkg::KIND_ENTER) && !m_tdata[0]))
        |-> (m_tdata[32:1] == tet_pkg::ID_NONE))
        else $error("empty result with an id");

    // An accepted enter keeps the request side busy in the next cycle
    a_busy_after_enter: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == tet_pkg::ACT_ENTER) |=> !s_tready)
        else $error("request side ready right after an enter");

endmodule

bind timed_event_table_core tet_checker u_tet_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/sv/timed_event_table_core_tb.sv
// ---------------------------------------------------------------------------
// timed_event_table_core_tb
// Self-checking bench for the timed event table. Requests go in on the
// slave stream in random bursts, responses are drained on the master stream
// under a changing stall pattern with one long hold-off. A scoreboard keeps
// its own copy of the table, predicts every response and compares each one
// in arrival order.
// ---------------------------------------------------------------------------
module timed_event_table_core_tb;

    import tet_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 36;
    localparam int LONG_HOLD     = 400;
    localparam int DRAIN_CYCLES  = 2 * ENTRIES + 16;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_REPORTS   = 10;

    // Action codes the block takes and drops without a response
    localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

    // Due and execute times cluster in this window so events actually fire
    localparam logic [TIME_W-1:0] WIN_BASE = 32'h0001_0000;
    localparam int                WIN_SPAN = 255;

    // One response as seen on the master stream
    typedef struct packed {
        tet_kind_t          kind;
        logic               ok;
        logic [ID_W-1:0]    id;
        logic [SESS_W-1:0]  session;
        logic [CODE_W-1:0]  code;
        logic [ARG_W-1:0]   arg;
        logic               last;
    } tet_result_t;

    // Scoreboard: shadow event table plus the queue of predicted responses
    class event_table_scoreboard;
        bit                 busy[ENTRIES];
        logic [ID_W-1:0]    ev_id[ENTRIES];
        logic [TIME_W-1:0]  ev_due[ENTRIES];
        logic [SESS_W-1:0]  ev_sess[ENTRIES];
        logic [CODE_W-1:0]  ev_code[ENTRIES];
        logic [ARG_W-1:0]   ev_arg[ENTRIES];
        logic [ID_W-1:0]    issued_id;
        tet_result_t        pending_results[$];
        int                 mismatches;

        function new();
            foreach (busy[i])
                busy[i] = 1'b0;
            issued_id  = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void add_result(tet_kind_t k, logic ok, logic [ID_W-1:0] id,
                                 logic [SESS_W-1:0] s, logic [CODE_W-1:0] c,
                                 logic [ARG_W-1:0] a, logic last);
            tet_result_t r;
            r.kind    = k;
            r.ok      = ok;
            r.id      = id;
            r.session = s;
            r.code    = c;
            r.arg     = a;
            r.last    = last;
            pending_results.push_back(r);
        endfunction

        // Pick the id of a live entry, or the latest id when the table is empty
        function logic [ID_W-1:0] pick_live_id();
            int live[$];
            for (int i = 0; i < ENTRIES; i++)
                if (busy[i])
                    live.push_back(i);
            if (live.size() == 0)
                return issued_id;
            return ev_id[live[$urandom_range(0, live.size() - 1)]];
        endfunction

        // Update the shadow table for one accepted request and queue its responses
        function void note_request(logic [ACT_W-1:0] act, logic [TIME_W-1:0] t,
                                   logic [SESS_W-1:0] s, logic [ID_W-1:0] eid,
                                   logic [CODE_W-1:0] c, logic [ARG_W-1:0] a);
            int               free_slot;
            int               fire_idx[$];
            logic [ID_W-1:0]  nid;
            logic             found;
            free_slot = -1;
            found     = 1'b0;
            case (act)
                ACT_ENTER:
                begin
                    for (int i = ENTRIES - 1; i >= 0; i--)
                        if (!busy[i])
                            free_slot = i;
                    if (free_slot >= 0)
                    begin
                        // Never hand out the all-ones id
                        nid = issued_id + 1'b1;
                        if (nid == ID_NONE)
                            nid = '0;
                        issued_id          = nid;
                        busy[free_slot]    = 1'b1;
                        ev_id[free_slot]   = nid;
                        ev_due[free_slot]  = t;
                        ev_sess[free_slot] = s;
                        ev_code[free_slot] = c;
                        ev_arg[free_slot]  = a;
                        add_result(KIND_ENTER, 1'b1, nid, '0, '0, '0, 1'b1);
                    end
                    else
                        add_result(KIND_ENTER, 1'b0, ID_NONE, '0, '0, '0, 1'b1);
                end
                ACT_REM_ID:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (!found && busy[i] && ev_id[i] == eid)
                        begin
                            busy[i] = 1'b0;
                            found   = 1'b1;
                        end
                    add_result(KIND_REMOVED, 1'b0, ID_NONE, '0, '0, '0, 1'b1);
                end
                ACT_REM_SESS:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (busy[i] && ev_sess[i] == s)
                            busy[i] = 1'b0;
                    add_result(KIND_REMOVED, 1'b0, ID_NONE, '0, '0, '0, 1'b1);
                end
                ACT_EXEC:
                begin
                    // Fire due entries in slot order, capped per request
                    for (int i = 0; i < ENTRIES; i++)
                        if (busy[i] && ev_due[i] <= t && fire_idx.size() < MAX_RESULTS)
                            fire_idx.push_back(i);
                    for (int k = 0; k < fire_idx.size(); k++)
                    begin
                        add_result(KIND_FIRED, 1'b0, ev_id[fire_idx[k]],
                                   ev_sess[fire_idx[k]], ev_code[fire_idx[k]],
                                   ev_arg[fire_idx[k]], k == fire_idx.size() - 1);
                        busy[fire_idx[k]] = 1'b0;
                    end
                    if (fire_idx.size() == 0)
                        add_result(KIND_NONE, 1'b0, ID_NONE, '0, '0, '0, 1'b1);
                end
                ACT_CHECK:
                begin
                    for (int i = 0; i < ENTRIES; i++)
                        if (busy[i] && ev_sess[i] == s)
                            found = 1'b1;
                    add_result(KIND_CHECK, found, ID_NONE, '0, '0, '0, 1'b1);
                end
                default:
                    ;
            endcase
        endfunction

        function void report(string what, tet_result_t want, tet_result_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] %s\n  exp kind=%0d ok=%0b id=%h sess=%h code=%h arg=%h last=%0b",
                         $time, what, want.kind, want.ok, want.id, want.session,
                         want.code, want.arg, want.last,
                         "\n  got kind=%0d ok=%0b id=%h sess=%h code=%h arg=%h last=%0b",
                         got.kind, got.ok, got.id, got.session, got.code, got.arg,
                         got.last);
        endfunction

        // Compare one response against the oldest prediction
        function void check_response(tet_result_t got);
            tet_result_t want;
            if (pending_results.size() == 0)
            begin
                report("response with no prediction outstanding", '0, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind || got.ok !== want.ok || got.id !== want.id ||
                got.session !== want.session || got.code !== want.code ||
                got.arg !== want.arg || got.last !== want.last)
                report("response mismatch", want, got);
        endfunction
    endclass

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata  = '0;
    logic [ACT_W-1:0]       s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   m_tlast;

    event_table_scoreboard  sb;
    tet_result_t            seen;
    int                     burst_left = 0;
    int                     hold_req   = 0;

    timed_event_table_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stop a hung run
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timed_event_table_core_tb: FAIL");
        $finish;
    end

    // Drain responses: switch between stall patterns, honor a long hold-off
    initial
    begin : response_drain
        int mode;
        int mode_left;
        int hold_left;
        int phase;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        phase     = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 1) == 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ((phase % 7) >= 3);
                endcase
            end
        end
    end

    // Check every response transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind    = tet_kind_t'(m_tuser);
            seen.ok      = m_tdata[0];
            seen.id      = m_tdata[32:1];
            seen.session = m_tdata[64:33];
            seen.code    = m_tdata[80:65];
            seen.arg     = m_tdata[112:81];
            seen.last    = m_tlast;
            sb.check_response(seen);
        end
    end

    // Offer one request, pausing between bursts, and hold it until accepted
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [TIME_W-1:0] t,
                                input logic [SESS_W-1:0] s, input logic [ID_W-1:0] eid,
                                input logic [CODE_W-1:0] c, input logic [ARG_W-1:0] a);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {a, c, eid, s, t};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(act, t, s, eid, c, a);
        burst_left--;
    endtask

    // Build one random request; enter_pct sets how fast the table fills
    task automatic send_random_request(input int enter_pct, output bit counted);
        logic [ACT_W-1:0]   act;
        logic [TIME_W-1:0]  t;
        logic [SESS_W-1:0]  s;
        logic [ID_W-1:0]    eid;
        int                 roll;
        roll = $urandom_range(0, 99);
        if (roll < enter_pct)
            act = ACT_ENTER;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 25)
                act = ACT_REM_ID;
            else if (roll < 35)
                act = ACT_REM_SESS;
            else if (roll < 65)
                act = ACT_EXEC;
            else if (roll < 90)
                act = ACT_CHECK;
            else
                act = ACT_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST));
        end

        // Due time on enter, current time on execute
        roll = $urandom_range(0, 99);
        if (act == ACT_ENTER)
            t = (roll < 75) ? WIN_BASE + $urandom_range(0, WIN_SPAN) : $urandom;
        else if (roll < 65)
            t = WIN_BASE + $urandom_range(0, WIN_SPAN);
        else if (roll < 85)
            t = $urandom;
        else if (roll < 95)
            t = '0;
        else
            t = '1;

        // Few sessions, so removal and check hit often
        roll = $urandom_range(0, 99);
        if (roll < 80)
            s = $urandom_range(1, 6);
        else if (roll < 85)
            s = '0;
        else if (roll < 90)
            s = '1;
        else
            s = $urandom;

        roll = $urandom_range(0, 99);
        if (roll < 60)
            eid = sb.pick_live_id();
        else if (roll < 75)
            eid = sb.issued_id - $urandom_range(0, 8);
        else if (roll < 85)
            eid = ID_NONE;
        else
            eid = $urandom;

        send_request(act, t, s, eid, CODE_W'($urandom), $urandom);
        counted = (act <= ACT_CHECK);
    endtask

    initial
    begin : stimulus
        int unsigned phase_enter[RANDOM_PHASES] = '{35, 70, 35, 90, 30, 60, 20, 90};
        int          done;
        bit          counted;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table: check, nothing due, remove with the reserved id
        send_request(ACT_CHECK, '0, '0, '0, '0, '0);
        send_request(ACT_EXEC, '1, '0, '0, '0, '0);
        send_request(ACT_REM_ID, '0, '0, ID_NONE, '0, '0);
        // Field extremes on enter
        send_request(ACT_ENTER, '0, '0, '0, '0, '0);
        send_request(ACT_ENTER, '1, '1, '1, '1, '1);
        send_request(ACT_ENTER, 32'd5, 32'd7, '0, 16'ha5a5, 32'h5a5a_5a5a);
        send_request(ACT_CHECK, '0, '1, '0, '0, '0);
        send_request(ACT_CHECK, '0, 32'd7, '0, '0, '0);
        // Remove by id: reserved id misses, then a real one
        send_request(ACT_REM_ID, '0, '0, ID_NONE, '0, '0);
        send_request(ACT_REM_ID, '0, '0, 32'd2, '0, '0);
        send_request(ACT_REM_SESS, '0, 32'd7, '0, '0, '0);
        send_request(ACT_CHECK, '0, 32'd7, '0, '0, '0);
        // Fire at time zero, then nothing left due at zero
        send_request(ACT_EXEC, '0, '0, '0, '0, '0);
        send_request(ACT_EXEC, '0, '0, '0, '0, '0);
        send_request(ACT_ENTER, 32'd10, 32'd3, '0, 16'h0001, 32'h1);
        send_request(ACT_ENTER, 32'd20, 32'd3, '0, 16'h0002, 32'h2);
        // Fire everything left in slot order
        send_request(ACT_EXEC, '1, '0, '0, '0, '0);
        // Reserved actions are dropped
        send_request(ACT_RSVD_FIRST, '1, '1, '1, '1, '1);
        send_request(ACT_RSVD_FIRST + 3'd1, '0, '0, '0, '0, '0);
        send_request(ACT_RSVD_LAST, '1, '1, '1, '1, '1);
        send_request(ACT_REM_SESS, '0, '1, '0, '0, '0);
        send_request(ACT_REM_SESS, '0, '0, '0, '0, '0);

        // Random phases alternate between filling and draining the table
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // Hold off responses while the table fills, so the input stalls
            if (p == 3)
                hold_req = LONG_HOLD;
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                send_random_request(phase_enter[p], counted);
                if (counted)
                    done++;
            end
        end
        s_tvalid <= 1'b0;

        // Wait for the last responses, then let the block settle
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("timed_event_table_core_tb: PASS");
        else
            $display("timed_event_table_core_tb: FAIL");
        $finish;
    end

endmodule

>>> timed_event_table_core.f
design/tet_pkg.sv
design/tet_table.sv
design/tet_cmp.sv
design/tet_ctrl.sv
design/timed_event_table_core.sv
design/tet_checker.sv
tb/sv/timed_event_table_core_tb.sv
